>>> src/palette_rle_encoder_assert.svh
// ----------------------------------------------------------------------------
// Palette RLE encoder assertion macros
// Shared property forms used by the encoder RTL; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PALETTE_RLE_ENCODER_ASSERT_SVH
`define PALETTE_RLE_ENCODER_ASSERT_SVH

// A condition that must hold on every clock edge outside reset.
`define PRLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define PRLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/prle_pkg.sv
// ----------------------------------------------------------------------------
// Palette RLE encoder package
// Default sizes, field widths, operation and result codes, and controller states.
// ----------------------------------------------------------------------------
package prle_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int SECTOR_CELLS_DEF = 4096;
    localparam int BLOCK_BITS_DEF   = 16;

    // Port field widths.
    localparam int OPCODE_W   = 2;
    localparam int VALUE_W    = 16;
    localparam int SLOT_W     = 8;
    localparam int KIND_W     = 2;
    localparam int RIDX_W     = 8;
    localparam int RLEN_W     = 13;
    localparam int PCOUNT_W   = 9;
    localparam int ECOUNT_W   = 13;
    localparam int WORD_W     = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 64;
    localparam int M_USED_W   = RIDX_W + RLEN_W + PCOUNT_W + ECOUNT_W + WORD_W + 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_BLOCK = 2'd0,
        OP_END   = 2'd1,
        OP_READ  = 2'd2
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_RUN  = 2'd0,
        KIND_END  = 2'd1,
        KIND_WORD = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_END,
        ST_WORD
    } state_t;

endpackage

>>> src/palette_rle_encoder.sv
// Block value: a linear palette search that reads one stored word per cycle from the
// palette RAM; the search is skipped with an empty palette.
// A block value beyond the sector limit is dropped. A transaction that produces a result
// takes longer while an earlier result is still held in the output register.
// One transaction is in work at a time.
// Reset (rst_n low, asynchronous) clears all counters, the open run and the overflow flag.
// ----------------------------------------------------------------------------
// Palette RLE encoder
// Maps block values to palette indices, merges equal indices into runs and
// reports runs, end-of-sector summaries and palette words.
// ----------------------------------------------------------------------------
`include "palette_rle_encoder_assert.svh"

module palette_rle_encoder #(
    parameter int PALETTE_SIZE = prle_pkg::PALETTE_SIZE_DEF,
    parameter int SECTOR_CELLS = prle_pkg::SECTOR_CELLS_DEF,
    parameter int BLOCK_BITS   = prle_pkg::BLOCK_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // block_value [15:0], palette_index [23:16]
    input  logic [prle_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode [1:0]
    input  logic [prle_pkg::OPCODE_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // run_palette_index [7:0], run_length [20:8], palette_count [29:21],
    // entry_count [42:30], palette_word [58:43], word_valid [59], overflow [60]
    output logic [prle_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind [1:0]
    output logic [prle_pkg::KIND_W-1:0]      m_tuser
);

    import prle_pkg::*;

    localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int FW = $clog2(PALETTE_SIZE + 1);
    localparam int CW = $clog2(SECTOR_CELLS + 1);

    state_t state_reg, state_next;

    logic [FW-1:0]         fill_reg, fill_next;
    logic [AW-1:0]         open_idx_reg, open_idx_next;
    logic [CW-1:0]         open_len_reg, open_len_next;
    logic                  run_open_reg, run_open_next;
    logic [CW-1:0]         runs_reg, runs_next;
    logic [CW-1:0]         cells_reg, cells_next;
    logic                  ovf_reg, ovf_next;
    logic [FW-1:0]         scan_reg, scan_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic [AW-1:0]         hit_idx_reg, hit_idx_next;
    logic [BLOCK_BITS-1:0] value_reg, value_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [KIND_W-1:0]     m_tuser_reg, m_tuser_next;
    logic                  out_load;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [BLOCK_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [BLOCK_BITS-1:0] rd_data;

    opcode_t               in_op;
    logic [VALUE_W-1:0]    in_value;
    logic [SLOT_W-1:0]     in_slot;
    logic                  s_accept;
    logic                  out_free;
    logic                  cmp_hit;
    logic                  cmp_last;
    logic [AW-1:0]         new_idx;
    logic                  pal_full;
    logic                  sector_full;
    logic                  run_extend;
    logic                  need_emit;
    logic                  word_valid;

    prle_palette_ram #(
        .DEPTH (PALETTE_SIZE),
        .DW    (BLOCK_BITS),
        .AW    (AW)
    ) u_palette_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_op    = opcode_t'(s_tuser);
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_slot  = s_tdata[VALUE_W+SLOT_W-1:VALUE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // The search compares the word read in the previous cycle.
    assign cmp_hit  = cmp_vld_reg && (rd_data == value_reg);
    assign cmp_last = cmp_vld_reg && (FW'(cmp_idx_reg) == fill_reg - 1'b1);

    assign new_idx     = found_reg ? hit_idx_reg : fill_reg[AW-1:0];
    assign pal_full    = (fill_reg >= FW'(PALETTE_SIZE));
    assign sector_full = (cells_reg >= CW'(SECTOR_CELLS));
    assign run_extend  = run_open_reg && (new_idx == open_idx_reg);
    assign need_emit   = run_open_reg && !run_extend;
    assign word_valid  = (32'(slot_reg) < 32'(fill_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_op)
                        OP_BLOCK:
                        begin
                            if (!sector_full)
                            begin
                                state_next = (fill_reg == '0) ? ST_RUN : ST_SCAN;
                            end
                        end
                        OP_END:  state_next = ST_END;
                        OP_READ: state_next = ST_WORD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cmp_hit || cmp_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!found_reg && pal_full)
                begin
                    state_next = ST_IDLE;
                end
                else if (!need_emit || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_END, ST_WORD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result formation.
    always_comb
    begin
        fill_next     = fill_reg;
        open_idx_next = open_idx_reg;
        open_len_next = open_len_reg;
        run_open_next = run_open_reg;
        runs_next     = runs_reg;
        cells_next    = cells_reg;
        ovf_next      = ovf_reg;
        scan_next     = scan_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        hit_idx_next  = hit_idx_reg;
        value_next    = value_reg;
        slot_next     = slot_reg;

        wr_en   = 1'b0;
        wr_addr = fill_reg[AW-1:0];
        wr_data = value_reg;
        rd_en   = 1'b0;
        rd_addr = scan_reg[AW-1:0];

        out_load     = 1'b0;
        m_tuser_next = m_tuser_reg;
        m_tdata_next = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    value_next = BLOCK_BITS'(in_value);
                    slot_next  = in_slot;
                    case (in_op)
                        OP_BLOCK:
                        begin
                            if (sector_full)
                            begin
                                ovf_next = 1'b1;
                            end
                            scan_next  = '0;
                            found_next = 1'b0;
                        end
                        OP_READ:
                        begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(in_slot);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_en        = (scan_reg < fill_reg);
                scan_next    = scan_reg + 1'b1;
                cmp_vld_next = rd_en;
                cmp_idx_next = scan_reg[AW-1:0];
                if (cmp_hit)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                end
                else if (cmp_last)
                begin
                    cmp_vld_next = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (!found_reg && pal_full)
                begin
                    // No free slot: the cell is dropped.
                    ovf_next = 1'b1;
                end
                else if (!need_emit || out_free)
                begin
                    if (!found_reg)
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    cells_next = cells_reg + 1'b1;
                    if (run_extend)
                    begin
                        open_len_next = open_len_reg + 1'b1;
                    end
                    else
                    begin
                        if (need_emit)
                        begin
                            out_load     = 1'b1;
                            m_tuser_next = KIND_RUN;
                            m_tdata_next = M_TDATA_W'({ovf_reg, 1'b0, WORD_W'(0),
                                ECOUNT_W'(0), PCOUNT_W'(0), RLEN_W'(open_len_reg),
                                RIDX_W'(open_idx_reg)});
                        end
                        run_open_next = 1'b1;
                        open_idx_next = new_idx;
                        open_len_next = CW'(1);
                        runs_next     = runs_reg + 1'b1;
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    m_tuser_next = KIND_END;
                    m_tdata_next = M_TDATA_W'({ovf_reg, 1'b0, WORD_W'(0),
                        ECOUNT_W'(runs_reg), PCOUNT_W'(fill_reg),
                        run_open_reg ? RLEN_W'(open_len_reg) : RLEN_W'(0),
                        run_open_reg ? RIDX_W'(open_idx_reg) : RIDX_W'(0)});
                    // The palette words stay in memory but are hidden by the zero fill.
                    fill_next     = '0;
                    open_idx_next = '0;
                    open_len_next = '0;
                    run_open_next = 1'b0;
                    runs_next     = '0;
                    cells_next    = '0;
                    ovf_next      = 1'b0;
                end
            end
            ST_WORD:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    m_tuser_next = KIND_WORD;
                    m_tdata_next = M_TDATA_W'({ovf_reg, word_valid,
                        word_valid ? WORD_W'(rd_data) : WORD_W'(0),
                        ECOUNT_W'(0), PCOUNT_W'(0), RLEN_W'(0), RIDX_W'(0)});
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            open_idx_reg <= '0;
            open_len_reg <= '0;
            run_open_reg <= 1'b0;
            runs_reg     <= '0;
            cells_reg    <= '0;
            ovf_reg      <= 1'b0;
            scan_reg     <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            found_reg    <= 1'b0;
            hit_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            open_idx_reg <= open_idx_next;
            open_len_reg <= open_len_next;
            run_open_reg <= run_open_next;
            runs_reg     <= runs_next;
            cells_reg    <= cells_next;
            ovf_reg      <= ovf_next;
            scan_reg     <= scan_next;
            cmp_vld_reg  <= cmp_vld_next;
            cmp_idx_reg  <= cmp_idx_next;
            found_reg    <= found_next;
            hit_idx_reg  <= hit_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        slot_reg    <= slot_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `PRLE_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FW'(PALETTE_SIZE), "palette fill beyond size")
    `PRLE_ASSERT_ALWAYS(a_cells_bound, cells_reg <= CW'(SECTOR_CELLS), "cell count beyond sector")
    `PRLE_ASSERT_IMP(a_open_len, run_open_reg, open_len_reg != '0, "open run has zero length")
    `PRLE_ASSERT_IMP(a_no_runs, !run_open_reg, runs_reg == '0, "runs counted with no open run")
    `PRLE_ASSERT_IMP(a_out_free, out_load, !m_tvalid_reg || m_tready, "result overwritten")

endmodule

>>> src/prle_palette_ram.sv
// ----------------------------------------------------------------------------
// Palette store
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module prle_palette_ram #(
    parameter int DEPTH = prle_pkg::PALETTE_SIZE_DEF,
    parameter int DW    = prle_pkg::BLOCK_BITS_DEF,
    parameter int AW    = $clog2(prle_pkg::PALETTE_SIZE_DEF)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> dv/palette_rle_encoder_tb.sv
// ----------------------------------------------------------------------------
// Palette RLE encoder testbench
// Drives block values, end-of-sector and palette reads over the input stream,
// predicts every run, summary and palette word, and checks each output
// transaction field by field under several idle and backpressure patterns.
// ----------------------------------------------------------------------------
module palette_rle_encoder_tb;

    import prle_pkg::*;

    localparam int                  PAL_DEPTH    = PALETTE_SIZE_DEF;
    localparam int                  MAX_CELLS    = SECTOR_CELLS_DEF;
    localparam logic [OPCODE_W-1:0] OP_UNUSED    = 2'd3;
    localparam int                  HOLD_CYCLES  = 400;
    localparam int                  SETTLE_WAIT  = 300;
    localparam int                  CYCLE_LIMIT  = 2000000;
    localparam int                  RANDOM_ITEMS = 125;

    typedef struct {
        kind_t               kind;
        logic [RIDX_W-1:0]   run_index;
        logic [RLEN_W-1:0]   run_len;
        logic [PCOUNT_W-1:0] pal_count;
        logic [ECOUNT_W-1:0] entry_count;
        logic [WORD_W-1:0]   word;
        logic                word_valid;
        logic                overflow;
    } enc_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;

    // Predictor state for the current sector.
    logic [WORD_W-1:0]     pal_words [PAL_DEPTH];
    int unsigned           pal_fill;
    int unsigned           run_slot;
    int unsigned           run_cells;
    bit                    run_active;
    int unsigned           sector_runs;
    int unsigned           sector_cells;
    bit                    sticky_overflow;

    enc_result_t           expected_results [$];

    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    hold_requests = 0;
    int                    hold_served = 0;
    int                    hold_left = 0;
    int                    mismatch_count;
    int                    cycle_count;
    int                    items_sent;
    int                    results_checked;
    int                    sectors_closed;
    int                    overflow_results;

    palette_rle_encoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic enc_result_t make_result(kind_t k, int unsigned ridx, int unsigned rlen,
                                                int unsigned pcount, int unsigned ecount,
                                                int unsigned word, bit valid);
        enc_result_t r;
        r.kind        = k;
        r.run_index   = ridx[RIDX_W-1:0];
        r.run_len     = rlen[RLEN_W-1:0];
        r.pal_count   = pcount[PCOUNT_W-1:0];
        r.entry_count = ecount[ECOUNT_W-1:0];
        r.word        = word[WORD_W-1:0];
        r.word_valid  = valid;
        r.overflow    = sticky_overflow;
        return r;
    endfunction

    function automatic void clear_sector_state();
        pal_fill        = 0;
        run_slot        = 0;
        run_cells       = 0;
        run_active      = 0;
        sector_runs     = 0;
        sector_cells    = 0;
        sticky_overflow = 0;
    endfunction

    // Updates the predicted encoder state for one accepted transaction and queues
    // the result that it causes, if any.
    function automatic void encode_transaction(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] value,
                                               logic [SLOT_W-1:0] slot);
        int unsigned idx;
        bit          hit;
        idx = 0;
        hit = 0;
        if (op == OP_BLOCK)
        begin
            if (sector_cells >= MAX_CELLS)
            begin
                sticky_overflow = 1;
                return;
            end
            for (int p = 0; p < pal_fill; p++)
            begin
                if (!hit && pal_words[p] == value)
                begin
                    idx = p;
                    hit = 1;
                end
            end
            if (!hit)
            begin
                // A new value with no free slot is dropped entirely.
                if (pal_fill >= PAL_DEPTH)
                begin
                    sticky_overflow = 1;
                    return;
                end
                idx = pal_fill;
                pal_words[idx] = value;
                pal_fill++;
            end
            sector_cells++;
            if (run_active && idx == run_slot)
            begin
                run_cells++;
            end
            else
            begin
                if (run_active)
                    expected_results.push_back(make_result(KIND_RUN, run_slot, run_cells,
                                                           0, 0, 0, 0));
                run_active = 1;
                run_slot   = idx;
                run_cells  = 1;
                sector_runs++;
            end
        end
        else if (op == OP_END)
        begin
            expected_results.push_back(make_result(KIND_END,
                                                   run_active ? run_slot : 0,
                                                   run_active ? run_cells : 0,
                                                   pal_fill, sector_runs, 0, 0));
            clear_sector_state();
        end
        else if (op == OP_READ)
        begin
            if (slot < pal_fill)
                expected_results.push_back(make_result(KIND_WORD, 0, 0, 0, 0,
                                                       pal_words[slot], 1));
            else
                expected_results.push_back(make_result(KIND_WORD, 0, 0, 0, 0, 0, 0));
        end
    endfunction

    task automatic send_item(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] value,
                             logic [SLOT_W-1:0] slot);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {slot, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        encode_transaction(op, value, slot);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Lowers tvalid and waits until every predicted result has been received.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        enc_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result transaction, kind %0d", m_tuser);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind", want.kind, m_tuser);
        compare_field("run_palette_index", want.run_index, m_tdata[7:0]);
        compare_field("run_length", want.run_len, m_tdata[20:8]);
        compare_field("palette_count", want.pal_count, m_tdata[29:21]);
        compare_field("entry_count", want.entry_count, m_tdata[42:30]);
        compare_field("palette_word", want.word, m_tdata[58:43]);
        compare_field("word_valid", want.word_valid, m_tdata[59]);
        compare_field("overflow", want.overflow, m_tdata[60]);
        results_checked++;
        if (want.kind == KIND_END)
            sectors_closed++;
        if (want.overflow)
            overflow_results++;
    endfunction

    // Output side: checks every accepted transaction and drives tready, with a
    // long hold-off whenever the stimulus asks for one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
        if (hold_served < hold_requests)
        begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run timed out after %0d cycles.", cycle_count);
        $display("FAILURE");
        $finish;
    end

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    task automatic test_directed();
        send_item(OP_END, 16'h0000, 8'h00);           // empty sector
        send_item(OP_READ, 16'h0000, 8'h00);          // read on an empty palette
        send_item(OP_READ, 16'h0000, 8'hFF);
        send_item(OP_BLOCK, 16'h0000, 8'h00);
        send_item(OP_BLOCK, 16'h0000, 8'hFF);
        send_item(OP_BLOCK, 16'hFFFF, 8'h00);
        send_item(OP_BLOCK, 16'hFFFF, 8'h00);
        send_item(OP_BLOCK, 16'hFFFF, 8'h00);
        send_item(OP_BLOCK, 16'h0000, 8'h00);
        send_item(OP_READ, 16'h0000, 8'h00);
        send_item(OP_READ, 16'hFFFF, 8'h01);
        send_item(OP_READ, 16'h0000, 8'h02);          // one past the fill
        send_item(OP_UNUSED, 16'hAAAA, 8'h55);
        send_item(OP_BLOCK, 16'h5555, 8'hAA);
        send_item(OP_BLOCK, 16'h8000, 8'h00);
        send_item(OP_READ, 16'h0000, 8'hFF);
        send_item(OP_END, 16'h0000, 8'h00);
        // Words stay in the store but are hidden once the sector is closed.
        send_item(OP_READ, 16'h0000, 8'h00);
        wait_for_results();
    endtask

    task automatic test_palette_full();
        logic [7:0] i8;
        for (int i = 0; i < PAL_DEPTH; i++)
        begin
            i8 = i[7:0];
            send_item(OP_BLOCK, {i8, ~i8}, 8'h00);
        end
        send_item(OP_BLOCK, 16'h1234, 8'h00);
        send_item(OP_BLOCK, 16'h4321, 8'h00);
        send_item(OP_BLOCK, 16'h00FF, 8'h00);         // already stored, still counted
        send_item(OP_READ, 16'h0000, 8'hFF);
        send_item(OP_READ, 16'h0000, 8'h00);
        send_item(OP_END, 16'h0000, 8'h00);
        send_item(OP_READ, 16'h0000, 8'h00);
        wait_for_results();
    endtask

    task automatic test_sector_full();
        for (int i = 0; i < MAX_CELLS + 2; i++)
            send_item(OP_BLOCK, 16'hC3C3, 8'h00);
        send_item(OP_END, 16'h0000, 8'h00);
        wait_for_results();
        // Alternating values give the largest run count a sector allows.
        set_idling(0, 51);
        for (int i = 0; i < MAX_CELLS; i++)
            send_item(OP_BLOCK, i[0] ? 16'h7001 : 16'h0E00, 8'h00);
        send_item(OP_END, 16'h0000, 8'h00);
        wait_for_results();
    endtask

    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 5 == 4)
                send_item(OP_READ, 16'h0000, 8'($urandom_range(0, 3)));
            else
                send_item(OP_BLOCK, 16'($urandom_range(0, 3)), 8'h00);
        end
        send_item(OP_END, 16'h0000, 8'h00);
        wait_for_results();
    endtask

    // Mostly well-formed sector traffic: runs drawn from a small value pool,
    // reads of filled slots and sector ends, with some noise mixed in.
    task automatic send_random_traffic(int target);
        logic [WORD_W-1:0] pool [40];
        int                pool_size;
        int                count;
        int                pick;
        int                repeat_len;
        logic [WORD_W-1:0] value;
        pool_size = 0;
        count = 0;
        while (count < target)
        begin
            if (pool_size == 0)
            begin
                pool_size = ($urandom_range(9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 6);
                for (int i = 0; i < pool_size; i++)
                    pool[i] = 16'($urandom_range(0, 65535));
            end
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                value = pool[$urandom_range(0, pool_size - 1)];
                repeat_len = $urandom_range(1, 6);
                for (int i = 0; i < repeat_len; i++)
                    send_item(OP_BLOCK, value, 8'($urandom_range(0, 255)));
                count += repeat_len;
            end
            else if (pick < 80)
            begin
                if (pal_fill > 0 && $urandom_range(3) != 0)
                    send_item(OP_READ, 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, pal_fill - 1)));
                else
                    send_item(OP_READ, 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 255)));
                count++;
            end
            else if (pick < 85)
            begin
                send_item(OP_UNUSED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end
            else if (pick < 92)
            begin
                send_item(OP_END, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                pool_size = 0;
                count++;
            end
            else
            begin
                send_item(OP_BLOCK, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                count++;
            end
        end
        wait_for_results();
    endtask

    task automatic test_random();
        set_idling(0, 0);
        send_random_traffic(RANDOM_ITEMS);
        set_idling(51, 0);
        send_random_traffic(RANDOM_ITEMS);
        set_idling(0, 51);
        send_random_traffic(RANDOM_ITEMS);
        set_idling(38, 38);
        send_random_traffic(RANDOM_ITEMS);
    endtask

    initial
    begin
        mismatch_count   = 0;
        items_sent       = 0;
        results_checked  = 0;
        sectors_closed   = 0;
        overflow_results = 0;
        clear_sector_state();
        set_idling(0, 0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        set_idling(51, 0);
        test_palette_full();
        set_idling(0, 0);
        test_sector_full();
        set_idling(0, 0);
        test_backpressure();
        test_random();

        wait_for_results();
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("Sent %0d items and checked %0d results across %0d sectors.",
                 items_sent, results_checked, sectors_closed);
        $display("Covered full palette, full sector, %0d flagged results and long output stalls.",
                 overflow_results);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            if (expected_results.size() != 0)
                $error("%0d expected results never arrived", expected_results.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
